/* sv/bpss_pkg.sv */
// Shared types and constants for the bidirectional position setpoint stepper.
package bpss_pkg;

    localparam int BPSS_COUNTS_PER_REV = 1600;
    localparam int BPSS_REV_BITS       = 24;

    localparam int OP_W     = 3;
    localparam int IN_REV_W = 24;
    localparam int POS_W    = 11;
    localparam int CPR_W    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 3'd0,
        OP_ONE_WAY  = 3'd1,
        OP_TWO_WAY  = 3'd2,
        OP_INC      = 3'd3,
        OP_DEC      = 3'd4
    } t_op;

endpackage

/* sv/bidirectional_position_setpoint_stepper.sv */
// Position setpoint stepper: move commands, limits and one-count ticks.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  command  | i_valid / o_ready  | i_op, i_start_*, i_stop_*, i_back_*
//  result   | o_valid / i_ready  | o_now_rev, o_now_pos, o_up_enabled,
//           |                    | o_down_enabled, o_stepped
//
// Each command passes through the input register, then is computed and updates
// state into the result register.
// One command per cycle is sustained while i_ready is high; the single signed
// position compare (revolution difference times COUNTS_PER_REV) sets the cycle path.
// Synchronous active-low reset clears position, limits, enables and valids.
// A stalled result holds the state; the input register takes one more command.
module bidirectional_position_setpoint_stepper
    import bpss_pkg::*;
#(
    parameter int COUNTS_PER_REV = BPSS_COUNTS_PER_REV,
    parameter int REV_BITS       = BPSS_REV_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [IN_REV_W-1:0] i_start_rev,
    input  logic [POS_W-1:0]           i_start_pos,
    input  logic signed [IN_REV_W-1:0] i_stop_rev,
    input  logic [POS_W-1:0]           i_stop_pos,
    input  logic signed [IN_REV_W-1:0] i_back_rev,
    input  logic [POS_W-1:0]           i_back_pos,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [IN_REV_W-1:0] o_now_rev,
    output logic [POS_W-1:0]           o_now_pos,
    output logic                       o_up_enabled,
    output logic                       o_down_enabled,
    output logic                       o_stepped
);

    localparam int LIN_W = REV_BITS + CPR_W + 3;
    localparam int EXT_W = REV_BITS + IN_REV_W;
    localparam logic [CPR_W:0] CPR_M1 = (CPR_W+1)'(COUNTS_PER_REV - 1);
    localparam logic signed [LIN_W-1:0] CPR_L = LIN_W'(COUNTS_PER_REV);

    // input register
    logic                r_in_vld;
    logic [OP_W-1:0]     r_op;
    logic [IN_REV_W-1:0] r_start_rev, r_stop_rev, r_back_rev;
    logic [POS_W-1:0]    r_start_pos, r_stop_pos, r_back_pos;

    // state and result register
    logic                r_out_vld, n_out_vld;
    logic                r_stepped, n_stepped;
    logic [REV_BITS-1:0] r_now_rev, n_now_rev;
    logic [POS_W-1:0]    r_now_pos, n_now_pos;
    logic [REV_BITS-1:0] r_up_rev, n_up_rev;
    logic [POS_W-1:0]    r_up_pos, n_up_pos;
    logic [REV_BITS-1:0] r_dn_rev, n_dn_rev;
    logic [POS_W-1:0]    r_dn_pos, n_dn_pos;
    logic                r_up_act, n_up_act;
    logic                r_dn_act, n_dn_act;

    logic                out_free, adv;
    logic [EXT_W-1:0]    s_ext, e_ext, b_ext, now_ext;
    logic [REV_BITS-1:0] s_rev, e_rev, b_rev;
    logic [REV_BITS-1:0] x_rev, y_rev;
    logic [POS_W-1:0]    x_pos, y_pos;
    logic signed [REV_BITS:0]  rev_diff;
    logic signed [LIN_W-1:0]   diff_ext, prod, lin;
    logic                x_lt_y, x_eq_y;

    assign out_free = !r_out_vld || i_ready;
    assign adv      = r_in_vld && out_free;
    assign o_ready  = !r_in_vld || out_free;

    // revolution inputs: sign-extend from the port width, cut to REV_BITS
    assign s_ext = {{REV_BITS{r_start_rev[IN_REV_W-1]}}, r_start_rev};
    assign e_ext = {{REV_BITS{r_stop_rev[IN_REV_W-1]}}, r_stop_rev};
    assign b_ext = {{REV_BITS{r_back_rev[IN_REV_W-1]}}, r_back_rev};
    assign s_rev = s_ext[REV_BITS-1:0];
    assign e_rev = e_ext[REV_BITS-1:0];
    assign b_rev = b_ext[REV_BITS-1:0];

    // one shared compare: x < y and x == y on rev * COUNTS_PER_REV + pos
    always_comb begin
        priority if (r_op == OP_ONE_WAY) begin
            x_rev = e_rev;     x_pos = r_stop_pos;
            y_rev = s_rev;     y_pos = r_start_pos;
        end else if (r_op == OP_INC) begin
            x_rev = r_now_rev; x_pos = r_now_pos;
            y_rev = r_up_rev;  y_pos = r_up_pos;
        end else begin
            x_rev = r_dn_rev;  x_pos = r_dn_pos;
            y_rev = r_now_rev; y_pos = r_now_pos;
        end
    end

    assign rev_diff = $signed({x_rev[REV_BITS-1], x_rev})
                    - $signed({y_rev[REV_BITS-1], y_rev});
    assign diff_ext = {{(LIN_W-REV_BITS-1){rev_diff[REV_BITS]}}, rev_diff};
    assign prod     = diff_ext * CPR_L;
    assign lin      = prod + $signed(LIN_W'(x_pos)) - $signed(LIN_W'(y_pos));
    assign x_lt_y   = lin[LIN_W-1];
    assign x_eq_y   = (lin == '0);

    always_comb begin
        n_now_rev = r_now_rev;
        n_now_pos = r_now_pos;
        n_up_rev  = r_up_rev;
        n_up_pos  = r_up_pos;
        n_dn_rev  = r_dn_rev;
        n_dn_pos  = r_dn_pos;
        n_up_act  = r_up_act;
        n_dn_act  = r_dn_act;
        n_stepped = 1'b0;
        unique case (r_op)
            OP_CLEAR: begin
                n_now_rev = '0;
                n_now_pos = '0;
                n_up_rev  = '0;
                n_up_pos  = '0;
                n_dn_rev  = '0;
                n_dn_pos  = '0;
            end
            OP_ONE_WAY: begin
                n_now_rev = s_rev;
                n_now_pos = r_start_pos;
                priority if (x_lt_y) begin
                    n_dn_rev = e_rev;
                    n_dn_pos = r_stop_pos;
                    n_up_rev = s_rev;
                    n_up_pos = r_start_pos;
                    n_up_act = 1'b0;
                    n_dn_act = 1'b1;
                end else if (x_eq_y) begin
                    n_up_act = 1'b0;
                    n_dn_act = 1'b0;
                end else begin
                    n_dn_rev = s_rev;
                    n_dn_pos = r_start_pos;
                    n_up_rev = e_rev;
                    n_up_pos = r_stop_pos;
                    n_up_act = 1'b1;
                    n_dn_act = 1'b0;
                end
            end
            OP_TWO_WAY: begin
                n_now_rev = s_rev;
                n_now_pos = r_start_pos;
                n_up_rev  = b_rev;
                n_up_pos  = r_back_pos;
                n_dn_rev  = e_rev;
                n_dn_pos  = r_stop_pos;
                n_up_act  = 1'b1;
                n_dn_act  = 1'b1;
            end
            OP_INC: begin
                if (r_up_act) begin
                    if (x_lt_y) begin
                        n_stepped = 1'b1;
                        if ((CPR_W+1)'(r_now_pos) < CPR_M1) begin
                            n_now_pos = r_now_pos + 1'b1;
                        end else begin
                            n_now_pos = '0;
                            n_now_rev = r_now_rev + 1'b1;
                        end
                    end else begin
                        n_up_act = 1'b0;
                    end
                end
            end
            OP_DEC: begin
                if (r_dn_act) begin
                    if (x_lt_y) begin
                        n_stepped = 1'b1;
                        if (r_now_pos != '0) begin
                            n_now_pos = r_now_pos - 1'b1;
                        end else begin
                            n_now_pos = CPR_M1[POS_W-1:0];
                            n_now_rev = r_now_rev - 1'b1;
                        end
                    end else begin
                        n_dn_act = 1'b0;
                    end
                end
            end
            default: begin
                // unused codes report the state unchanged
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (adv) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_stepped <= 1'b0;
            r_now_rev <= '0;
            r_now_pos <= '0;
            r_up_rev  <= '0;
            r_up_pos  <= '0;
            r_dn_rev  <= '0;
            r_dn_pos  <= '0;
            r_up_act  <= 1'b0;
            r_dn_act  <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (i_valid && o_ready) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_stepped <= n_stepped;
                r_now_rev <= n_now_rev;
                r_now_pos <= n_now_pos;
                r_up_rev  <= n_up_rev;
                r_up_pos  <= n_up_pos;
                r_dn_rev  <= n_dn_rev;
                r_dn_pos  <= n_dn_pos;
                r_up_act  <= n_up_act;
                r_dn_act  <= n_dn_act;
            end
        end
    end

    // command payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op        <= i_op;
            r_start_rev <= i_start_rev;
            r_start_pos <= i_start_pos;
            r_stop_rev  <= i_stop_rev;
            r_stop_pos  <= i_stop_pos;
            r_back_rev  <= i_back_rev;
            r_back_pos  <= i_back_pos;
        end
    end

    assign now_ext        = {{IN_REV_W{r_now_rev[REV_BITS-1]}}, r_now_rev};
    assign o_valid        = r_out_vld;
    assign o_now_rev      = now_ext[IN_REV_W-1:0];
    assign o_now_pos      = r_now_pos;
    assign o_up_enabled   = r_up_act;
    assign o_down_enabled = r_dn_act;
    assign o_stepped      = r_stepped;

endmodule

/* sv/bpss_chk.sv */
// Port-level checker for the position setpoint stepper, bound to the top level.
module bpss_chk
    import bpss_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [IN_REV_W-1:0] o_now_rev,
    input logic [POS_W-1:0]           o_now_pos,
    input logic                       o_up_enabled,
    input logic                       o_down_enabled,
    input logic                       o_stepped
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // hold a stalled result
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_now_rev) && $stable(o_now_pos)
            && $stable(o_stepped))
        else $error("stalled result changed");

    // a step leaves its direction enabled
    a_step_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stepped |-> o_up_enabled || o_down_enabled)
        else $error("step reported with both directions disabled");

    // input back-pressure only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a waiting result");

endmodule

bind bidirectional_position_setpoint_stepper bpss_chk u_bpss_chk (.*);
